// ----- rtl/ubxd_pkg.sv -----
// ----------------------------------------------------------------------------
// UBX deframer package
// Shared phase encoding, event codes and the result record of the parser.
// ----------------------------------------------------------------------------
package ubxd_pkg;

  localparam int unsigned MAX_PAYLOAD_DEF = 1024;

  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;

  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_DATA    = 3'd1;
  localparam logic [2:0] EV_OK      = 3'd2;
  localparam logic [2:0] EV_BADSUM  = 3'd3;
  localparam logic [2:0] EV_TOOLONG = 3'd4;

  typedef enum logic [3:0] {
    PH_SYNC1   = 4'd0,
    PH_SYNC2   = 4'd1,
    PH_CLASS   = 4'd2,
    PH_ID      = 4'd3,
    PH_LEN1    = 4'd4,
    PH_LEN2    = 4'd5,
    PH_PAYLOAD = 4'd6,
    PH_CKA     = 4'd7,
    PH_CKB     = 4'd8
  } phase_t;

  typedef struct packed {
    logic [2:0]  ev;
    logic [7:0]  data_byte;
    logic [15:0] byte_index;
    logic [7:0]  msg_class;
    logic [7:0]  msg_id;
    logic [15:0] msg_len;
  } res_t;

endpackage

// ----- rtl/ubxd_parser.sv -----
// ----------------------------------------------------------------------------
// UBX frame parser
// Per-byte phase machine with Fletcher-8 checksum; one byte per step strobe.
// ----------------------------------------------------------------------------
module ubxd_parser #(
  parameter int unsigned MAX_PAYLOAD = ubxd_pkg::MAX_PAYLOAD_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step,
  input  logic [7:0]     rx_byte,
  output ubxd_pkg::res_t res
);

  localparam logic [15:0] MaxLen = 16'(MAX_PAYLOAD);

  ubxd_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  sum_a_r, sum_a_nxt;
  logic [7:0]  sum_b_r, sum_b_nxt;
  logic [7:0]  class_r, class_nxt;
  logic [7:0]  id_r, id_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] cnt_r, cnt_nxt;

  logic [7:0]  acc_a;
  logic [7:0]  acc_b;
  logic [15:0] len_full;
  logic [15:0] cnt_inc;

  assign acc_a    = sum_a_r + rx_byte;
  assign acc_b    = sum_b_r + acc_a;
  assign len_full = {rx_byte, len_r[7:0]};
  assign cnt_inc  = cnt_r + 16'd1;

  // next state
  always_comb begin
    phase_nxt = phase_r;
    sum_a_nxt = sum_a_r;
    sum_b_nxt = sum_b_r;
    class_nxt = class_r;
    id_nxt    = id_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    case (phase_r)
      ubxd_pkg::PH_SYNC1: begin
        if (rx_byte == ubxd_pkg::SYNC_FIRST) phase_nxt = ubxd_pkg::PH_SYNC2;
      end
      ubxd_pkg::PH_SYNC2: begin
        if (rx_byte == ubxd_pkg::SYNC_SECOND) begin
          phase_nxt = ubxd_pkg::PH_CLASS;
          sum_a_nxt = '0;
          sum_b_nxt = '0;
        end else begin
          phase_nxt = ubxd_pkg::PH_SYNC1;
        end
      end
      ubxd_pkg::PH_CLASS: begin
        class_nxt = rx_byte;
        sum_a_nxt = acc_a;
        sum_b_nxt = acc_b;
        phase_nxt = ubxd_pkg::PH_ID;
      end
      ubxd_pkg::PH_ID: begin
        id_nxt    = rx_byte;
        sum_a_nxt = acc_a;
        sum_b_nxt = acc_b;
        phase_nxt = ubxd_pkg::PH_LEN1;
      end
      ubxd_pkg::PH_LEN1: begin
        len_nxt   = {8'h00, rx_byte};
        sum_a_nxt = acc_a;
        sum_b_nxt = acc_b;
        phase_nxt = ubxd_pkg::PH_LEN2;
      end
      ubxd_pkg::PH_LEN2: begin
        len_nxt   = len_full;
        sum_a_nxt = acc_a;
        sum_b_nxt = acc_b;
        if (len_full == 16'd0) begin
          phase_nxt = ubxd_pkg::PH_CKA;
        end else if (len_full <= MaxLen) begin
          cnt_nxt   = '0;
          phase_nxt = ubxd_pkg::PH_PAYLOAD;
        end else begin
          phase_nxt = ubxd_pkg::PH_SYNC1;
        end
      end
      ubxd_pkg::PH_PAYLOAD: begin
        sum_a_nxt = acc_a;
        sum_b_nxt = acc_b;
        cnt_nxt   = cnt_inc;
        if (cnt_inc >= len_r) phase_nxt = ubxd_pkg::PH_CKA;
      end
      ubxd_pkg::PH_CKA: begin
        phase_nxt = (rx_byte == sum_a_r) ? ubxd_pkg::PH_CKB : ubxd_pkg::PH_SYNC1;
      end
      ubxd_pkg::PH_CKB: begin
        phase_nxt = ubxd_pkg::PH_SYNC1;
      end
      default: begin
        phase_nxt = ubxd_pkg::PH_SYNC1;
      end
    endcase
  end

  // result of the current byte
  always_comb begin
    res            = '0;
    res.msg_class  = class_nxt;
    res.msg_id     = id_nxt;
    res.msg_len    = len_nxt;
    case (phase_r)
      ubxd_pkg::PH_LEN2: begin
        if (len_full > MaxLen) res.ev = ubxd_pkg::EV_TOOLONG;
      end
      ubxd_pkg::PH_PAYLOAD: begin
        res.ev         = ubxd_pkg::EV_DATA;
        res.data_byte  = rx_byte;
        res.byte_index = cnt_r;
      end
      ubxd_pkg::PH_CKA: begin
        if (rx_byte != sum_a_r) res.ev = ubxd_pkg::EV_BADSUM;
      end
      ubxd_pkg::PH_CKB: begin
        res.ev = (rx_byte == sum_b_r) ? ubxd_pkg::EV_OK : ubxd_pkg::EV_BADSUM;
      end
      default: begin
        res.ev = ubxd_pkg::EV_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ubxd_pkg::PH_SYNC1;
      sum_a_r <= '0;
      sum_b_r <= '0;
      class_r <= '0;
      id_r    <= '0;
      len_r   <= '0;
      cnt_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      sum_a_r <= sum_a_nxt;
      sum_b_r <= sum_b_nxt;
      class_r <= class_nxt;
      id_r    <= id_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  a_ckb_returns: assert property (@(posedge clk) disable iff (!rst_n)
    step && phase_r == ubxd_pkg::PH_CKB |=> phase_r == ubxd_pkg::PH_SYNC1)
    else $error("parser did not return to hunting after second checksum byte");

  a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == ubxd_pkg::PH_PAYLOAD |-> cnt_r < len_r && len_r <= MaxLen)
    else $error("payload count out of range of declared length");

  a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(phase_r) && $stable(sum_a_r) && $stable(sum_b_r))
    else $error("parser state moved without a step");

endmodule

// ----- rtl/ubx_frame_deframer_core.sv -----
// ----------------------------------------------------------------------------
// UBX frame deframer core
// Byte stream in, one parse result per byte out (payload bytes and verdicts).
// ----------------------------------------------------------------------------
// Path: the input byte is registered in the input stage, and the parser result
// is registered in the result register that drives out_tvalid and out_tdata.
// Throughput: one byte per cycle while out_tready is high; input register feeds
// parser, result register parts the two sides, so a stalled output holds two bytes in flight at most.
// Reset (rst_n low, synchronous): parser hunts for first sync byte, checksums
// and header fields cleared, both pipeline registers emptied.
module ubx_frame_deframer_core #(
  parameter int unsigned MAX_PAYLOAD = ubxd_pkg::MAX_PAYLOAD_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [7:0] data_byte, [23:8] byte_index,
                                  // [31:24] msg_class, [39:32] msg_id,
                                  // [55:40] msg_len
  output logic [2:0]  out_tuser   // [2:0] event_res
);

  logic           s1_vld_r;
  logic [7:0]     s1_byte_r;
  logic           out_vld_r;
  ubxd_pkg::res_t out_res_r;
  ubxd_pkg::res_t res;
  logic           advance;
  logic           step;

  assign advance   = !out_vld_r || out_tready;
  assign step      = s1_vld_r && advance;
  assign in_tready = !s1_vld_r || advance;

  ubxd_parser #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .rx_byte(s1_byte_r),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_tready) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) s1_byte_r <= in_tdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) out_res_r <= res;
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_res_r.ev;
  assign out_tdata  = {out_res_r.msg_len, out_res_r.msg_id, out_res_r.msg_class,
                       out_res_r.byte_index, out_res_r.data_byte};

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && !advance |=> s1_vld_r && $stable(s1_byte_r))
    else $error("input stage lost a byte while output stalled");

  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_res_r.ev != ubxd_pkg::EV_DATA |->
      out_res_r.data_byte == 8'd0 && out_res_r.byte_index == 16'd0)
    else $error("payload fields set on a non-data result");

  a_step_fills: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_vld_r)
    else $error("parser step did not produce a result");

endmodule

// ----- tb/ubx_frame_deframer_core_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UBX frame deframer core testbench
// Streams sync pairs, headers, payloads and checksum pairs into the parser,
// both well formed and broken, and predicts every parse result from its own
// model of the frame state. Each output transfer is compared field by field
// with the oldest predicted result, with and without random valid/ready throttling.
// ----------------------------------------------------------------------------
module ubx_frame_deframer_core_test;

  localparam int unsigned PAYLOAD_LIMIT = ubxd_pkg::MAX_PAYLOAD_DEF;
  localparam int unsigned STALL_LIMIT   = 2000;

  typedef enum {
    FR_GOOD,
    FR_BAD_CKA,
    FR_BAD_CKB,
    FR_TOOLONG,
    FR_CUT,
    FR_NOISE
  } frame_kind_t;

  // Tracks the parser state and holds the results it must produce, in order.
  class ubx_result_tracker;
    ubxd_pkg::phase_t ph;
    logic [7:0]       sum_a;
    logic [7:0]       sum_b;
    logic [7:0]       cls;
    logic [7:0]       id;
    logic [15:0]      len;
    logic [15:0]      count;
    ubxd_pkg::res_t   pending_results[$];
    int unsigned      errors;

    function new();
      ph     = ubxd_pkg::PH_SYNC1;
      sum_a  = '0;
      sum_b  = '0;
      cls    = '0;
      id     = '0;
      len    = '0;
      count  = '0;
      errors = 0;
    endfunction

    function void fold(logic [7:0] b);
      sum_a = sum_a + b;
      sum_b = sum_b + sum_a;
    endfunction

    function void note_rx_byte(logic [7:0] b);
      ubxd_pkg::res_t r;
      r = '0;
      case (ph)
        ubxd_pkg::PH_SYNC1: begin
          if (b == ubxd_pkg::SYNC_FIRST) ph = ubxd_pkg::PH_SYNC2;
        end
        ubxd_pkg::PH_SYNC2: begin
          // a wrong second sync byte restarts the hunt, even a repeated first sync
          if (b == ubxd_pkg::SYNC_SECOND) begin
            ph    = ubxd_pkg::PH_CLASS;
            sum_a = '0;
            sum_b = '0;
          end else begin
            ph = ubxd_pkg::PH_SYNC1;
          end
        end
        ubxd_pkg::PH_CLASS: begin
          cls = b;
          fold(b);
          ph = ubxd_pkg::PH_ID;
        end
        ubxd_pkg::PH_ID: begin
          id = b;
          fold(b);
          ph = ubxd_pkg::PH_LEN1;
        end
        ubxd_pkg::PH_LEN1: begin
          len = {8'h00, b};
          fold(b);
          ph = ubxd_pkg::PH_LEN2;
        end
        ubxd_pkg::PH_LEN2: begin
          len[15:8] = b;
          fold(b);
          if (len == 16'd0) begin
            ph = ubxd_pkg::PH_CKA;
          end else if (len <= PAYLOAD_LIMIT) begin
            count = '0;
            ph    = ubxd_pkg::PH_PAYLOAD;
          end else begin
            r.ev = ubxd_pkg::EV_TOOLONG;
            ph   = ubxd_pkg::PH_SYNC1;
          end
        end
        ubxd_pkg::PH_PAYLOAD: begin
          r.ev         = ubxd_pkg::EV_DATA;
          r.data_byte  = b;
          r.byte_index = count;
          fold(b);
          count = count + 16'd1;
          if (count >= len) ph = ubxd_pkg::PH_CKA;
        end
        ubxd_pkg::PH_CKA: begin
          if (b == sum_a) begin
            ph = ubxd_pkg::PH_CKB;
          end else begin
            r.ev = ubxd_pkg::EV_BADSUM;
            ph   = ubxd_pkg::PH_SYNC1;
          end
        end
        ubxd_pkg::PH_CKB: begin
          r.ev = (b == sum_b) ? ubxd_pkg::EV_OK : ubxd_pkg::EV_BADSUM;
          ph   = ubxd_pkg::PH_SYNC1;
        end
        default: begin
          ph = ubxd_pkg::PH_SYNC1;
        end
      endcase
      r.msg_class = cls;
      r.msg_id    = id;
      r.msg_len   = len;
      pending_results = {pending_results, r};
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [2:0] ev, logic [55:0] d);
      ubxd_pkg::res_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none actual event %0d data %h",
                 $time, ev, d);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("event_res", 16'(want.ev), 16'(ev));
      compare_field("data_byte", 16'(want.data_byte), 16'(d[7:0]));
      compare_field("byte_index", want.byte_index, d[23:8]);
      compare_field("msg_class", 16'(want.msg_class), 16'(d[31:24]));
      compare_field("msg_id", 16'(want.msg_id), 16'(d[39:32]));
      compare_field("msg_len", want.msg_len, d[55:40]);
    endfunction

    function int unsigned pending_count();
      return pending_results.size();
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic [2:0]  out_tuser;

  int unsigned in_idle_pct  = 38;
  int unsigned out_idle_pct = 46;
  int unsigned frame_bytes  = 0;
  int unsigned quiet_cycles = 0;

  ubx_result_tracker tracker;

  ubx_frame_deframer_core #(
    .MAX_PAYLOAD(PAYLOAD_LIMIT)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= out_idle_pct);
  end

  // Check results, record accepted bytes, and watch for a stuck pipeline.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) tracker.check_result(out_tuser, out_tdata);
      if (in_tvalid && in_tready) tracker.note_rx_byte(in_tdata);
      if ((out_tvalid && out_tready) || (in_tvalid && in_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic send_frame(input frame_kind_t kind, input logic [7:0] cls,
                            input logic [7:0] id, input int unsigned plen);
    logic [7:0]  fb[$];
    logic [7:0]  ca;
    logic [7:0]  cb;
    int unsigned cut;
    ca = '0;
    cb = '0;
    if (kind == FR_NOISE) begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
      return;
    end
    fb = {fb, ubxd_pkg::SYNC_FIRST};
    fb = {fb, ubxd_pkg::SYNC_SECOND};
    fb = {fb, cls};
    fb = {fb, id};
    fb = {fb, plen[7:0]};
    fb = {fb, plen[15:8]};
    if (kind != FR_TOOLONG) begin
      repeat (plen) fb = {fb, 8'($urandom_range(255))};
      for (int i = 2; i < fb.size(); i++) begin
        ca = ca + fb[i];
        cb = cb + ca;
      end
      if (kind == FR_BAD_CKA) ca = ca ^ 8'($urandom_range(1, 255));
      if (kind == FR_BAD_CKB) cb = cb ^ 8'($urandom_range(1, 255));
      fb = {fb, ca};
      fb = {fb, cb};
    end
    if (kind == FR_CUT) begin
      // drop the tail so the next frame lands in the middle of this one
      cut = $urandom_range(2, fb.size() - 1);
      fb  = fb[0:cut-1];
    end
    foreach (fb[i]) send_byte(fb[i]);
    frame_bytes += fb.size();
  endtask

  task automatic run_traffic(input int unsigned target);
    int unsigned pick;
    int unsigned plen;
    while (frame_bytes < target) begin
      pick = $urandom_range(99);
      plen = ($urandom_range(19) == 0) ? $urandom_range(17, 120) : $urandom_range(0, 16);
      if (pick < 68) begin
        send_frame(FR_GOOD, 8'($urandom_range(255)), 8'($urandom_range(255)), plen);
      end else if (pick < 76) begin
        send_frame(FR_BAD_CKA, 8'($urandom_range(255)), 8'($urandom_range(255)), plen);
      end else if (pick < 84) begin
        send_frame(FR_BAD_CKB, 8'($urandom_range(255)), 8'($urandom_range(255)), plen);
      end else if (pick < 90) begin
        plen = ($urandom_range(3) == 0) ? 65535 : $urandom_range(PAYLOAD_LIMIT + 1, 65535);
        send_frame(FR_TOOLONG, 8'($urandom_range(255)), 8'($urandom_range(255)), plen);
      end else if (pick < 95) begin
        send_frame(FR_CUT, 8'($urandom_range(255)), 8'($urandom_range(255)), plen);
      end else begin
        send_frame(FR_NOISE, '0, '0, 0);
      end
    end
  endtask

  // Hold the input side until every predicted result has been drained.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (tracker.pending_count() != 0) @(negedge clk);
  endtask

  initial begin
    tracker = new();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // stray byte, then a repeated first sync that must not start a frame
    send_byte(8'h00);
    send_byte(ubxd_pkg::SYNC_FIRST);
    send_byte(ubxd_pkg::SYNC_FIRST);
    send_byte(ubxd_pkg::SYNC_SECOND);
    send_frame(FR_BAD_CKB, 8'hFF, 8'h00, 1);
    send_frame(FR_BAD_CKA, 8'h00, 8'hFF, 0);
    send_frame(FR_TOOLONG, 8'h01, 8'h02, PAYLOAD_LIMIT + 1);

    run_traffic(frame_bytes + 205);
    drain_results();

    in_idle_pct  = 46;
    out_idle_pct = 38;
    run_traffic(frame_bytes + 205);
    drain_results();

    in_idle_pct  = 0;
    out_idle_pct = 0;
    run_traffic(frame_bytes + 205);

    drain_results();
    repeat (8) @(negedge clk);
    if (tracker.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
